// ----- hdl/khc_pkg.sv -----
// Shared types, constants and bit functions for the keyed Hamming(15,11) codec.
// No dependencies; used by every module of the codec.
`default_nettype none

package khc_pkg;

    localparam int CODE_BITS = 15;
    localparam int DATA_BITS = 11;
    localparam int PAR_BITS  = 4;
    localparam int IDX_BITS  = 4;
    localparam int TBL_BITS  = CODE_BITS * IDX_BITS;

    localparam logic [TBL_BITS-1:0]  TABLE_RESET = 60'hEDC_BA98_7654_3210;
    localparam logic [CODE_BITS-1:0] CODE_MSB    = 15'h4000;
    localparam logic                 ACT_ENCODE  = 1'b0;
    localparam logic                 ACT_DECODE  = 1'b1;

    typedef logic [IDX_BITS-1:0]              idx_t;
    typedef idx_t [CODE_BITS-1:0]             idx_arr_t;
    typedef logic [TBL_BITS-1:0]              table_t;
    typedef logic [CODE_BITS-1:0]             code_t;
    typedef logic [PAR_BITS-1:0]              synd_t;

    typedef struct packed {
        logic valid;
        logic action;
        logic last;
    } ctl_t;

    function automatic idx_t table_entry(input table_t tbl, input int i);
        return tbl[IDX_BITS*i +: IDX_BITS];
    endfunction

    // largest entry index naming code bit j, else index 0
    function automatic idx_arr_t inverse_of(input table_t tbl);
        idx_arr_t inv;
        for (int j = 0; j < CODE_BITS; j++)
        begin
            inv[j] = '0;
            for (int i = 0; i < CODE_BITS; i++)
            begin
                if (table_entry(tbl, i) == IDX_BITS'(j))
                    inv[j] = IDX_BITS'(i);
            end
        end
        return inv;
    endfunction

    function automatic code_t hamming_encode(input logic [DATA_BITS-1:0] d);
        code_t code;
        int    idx;
        logic  par;
        code = '0;
        idx  = 0;
        for (int pos = 1; pos <= CODE_BITS; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                code[CODE_BITS-pos] = d[DATA_BITS-1-idx];
                idx++;
            end
        end
        for (int p = 0; p < PAR_BITS; p++)
        begin
            par = 1'b0;
            for (int pos = 1; pos <= CODE_BITS; pos++)
            begin
                if ((pos & (1 << p)) != 0)
                    par ^= code[CODE_BITS-pos];
            end
            code[CODE_BITS-(1 << p)] = par;
        end
        return code;
    endfunction

    function automatic synd_t syndrome_of(input code_t code);
        synd_t s;
        for (int p = 0; p < PAR_BITS; p++)
        begin
            s[p] = 1'b0;
            for (int pos = 1; pos <= CODE_BITS; pos++)
            begin
                if ((pos & (1 << p)) != 0)
                    s[p] ^= code[CODE_BITS-pos];
            end
        end
        return s;
    endfunction

    function automatic logic [DATA_BITS-1:0] extract_data(input code_t code);
        logic [DATA_BITS-1:0] d;
        int                   idx;
        d   = '0;
        idx = 0;
        for (int pos = 1; pos <= CODE_BITS; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                d[DATA_BITS-1-idx] = code[CODE_BITS-pos];
                idx++;
            end
        end
        return d;
    endfunction

    function automatic code_t permute_fwd(input code_t code, input table_t tbl);
        code_t out;
        idx_t  src;
        for (int dst = 0; dst < CODE_BITS; dst++)
        begin
            src = table_entry(tbl, dst);
            if (src < IDX_BITS'(CODE_BITS))
                out[CODE_BITS-1-dst] = code[IDX_BITS'(CODE_BITS - 1) - src];
            else
                out[CODE_BITS-1-dst] = 1'b0;
        end
        return out;
    endfunction

    function automatic code_t permute_inv(input code_t rx, input idx_arr_t inv);
        code_t out;
        for (int j = 0; j < CODE_BITS; j++)
            out[CODE_BITS-1-j] = rx[IDX_BITS'(CODE_BITS - 1) - inv[j]];
        return out;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/khc_inv_table.sv -----
// Registered inverse of the permutation table for the decode path.
// Depends on khc_pkg.
`default_nettype none

module khc_inv_table (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire khc_pkg::table_t   perm_table,
    output khc_pkg::idx_arr_t      inv_table
);

    khc_pkg::idx_arr_t inv_reg;
    khc_pkg::idx_arr_t inv_next;

    always_comb
    begin
        inv_next = khc_pkg::inverse_of(perm_table);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inv_reg <= khc_pkg::inverse_of(khc_pkg::TABLE_RESET);
        else
            inv_reg <= inv_next;
    end

    assign inv_table = inv_reg;

endmodule

`default_nettype wire

// ----- hdl/khc_pipe.sv -----
// Four-stage codec datapath: capture, encode or unpermute, permute or syndrome,
// correct and extract. Depends on khc_pkg.
`default_nettype none

module khc_pipe (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            accept,
    input  wire logic                            action,
    input  wire logic [khc_pkg::CODE_BITS-1:0]   data_word,
    input  wire logic                            last_word,
    input  wire khc_pkg::table_t                 perm_table,
    input  wire khc_pkg::idx_arr_t               inv_table,
    output logic                                 done,
    output logic [khc_pkg::CODE_BITS-1:0]        result_word,
    output logic                                 word_corrected,
    output logic                                 last_out
);

    khc_pkg::ctl_t  ctl1_reg, ctl2_reg, ctl3_reg, ctl4_reg;
    khc_pkg::code_t word1_reg, word2_reg, word3_reg, word4_reg;
    khc_pkg::synd_t synd3_reg;
    logic           corr4_reg;

    khc_pkg::code_t word2_next, word3_next, word4_next, code_fix;
    khc_pkg::synd_t synd3_next;
    logic           corr4_next;

    always_comb
    begin
        if (ctl1_reg.action == khc_pkg::ACT_DECODE)
            word2_next = khc_pkg::permute_inv(word1_reg, inv_table);
        else
            word2_next = khc_pkg::hamming_encode(word1_reg[khc_pkg::DATA_BITS-1:0]);
    end

    always_comb
    begin
        synd3_next = khc_pkg::syndrome_of(word2_reg);
        if (ctl2_reg.action == khc_pkg::ACT_DECODE)
            word3_next = word2_reg;
        else
            word3_next = khc_pkg::permute_fwd(word2_reg, perm_table);
    end

    always_comb
    begin
        code_fix = word3_reg;
        if (synd3_reg != '0)
            code_fix = word3_reg ^ (khc_pkg::CODE_MSB >> (synd3_reg - 4'd1));
        if (ctl3_reg.action == khc_pkg::ACT_DECODE)
        begin
            word4_next = {{(khc_pkg::CODE_BITS - khc_pkg::DATA_BITS){1'b0}},
                          khc_pkg::extract_data(code_fix)};
            corr4_next = (synd3_reg != '0);
        end
        else
        begin
            word4_next = word3_reg;
            corr4_next = 1'b0;
        end
    end

    // advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl1_reg <= '0;
            ctl2_reg <= '0;
            ctl3_reg <= '0;
            ctl4_reg <= '0;
        end
        else
        begin
            ctl1_reg <= '{valid: accept, action: action, last: last_word};
            ctl2_reg <= ctl1_reg;
            ctl3_reg <= ctl2_reg;
            ctl4_reg <= ctl3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        word1_reg <= data_word;
        word2_reg <= word2_next;
        word3_reg <= word3_next;
        synd3_reg <= synd3_next;
        word4_reg <= word4_next;
        corr4_reg <= corr4_next;
    end

    assign done           = ctl4_reg.valid;
    assign result_word    = word4_reg;
    assign word_corrected = corr4_reg;
    assign last_out       = ctl4_reg.last;

endmodule

`default_nettype wire

// ----- hdl/keyed_hamming_15_11_codec_unit.sv -----
// Top level of the keyed Hamming(15,11) codec: table register and pipeline.
// Depends on khc_pkg, khc_inv_table and khc_pipe.
//
//  channel   handshake            payload
//  command   start / busy         action, data_word, last_word
//  result    done (strobe)        result_word, word_corrected, last_out
//  config    cfg_valid/cfg_ready  cfg_data (perm_table)
//
// One word enters per cycle; each result strobes done once its word has passed
// through the four pipeline register stages.
// busy stays low: the pipeline never stalls and results cannot be held off.
// Reset clears all valid bits and loads the identity permutation.
// A table write is usable by a word started in the next cycle.
`default_nettype none

module keyed_hamming_15_11_codec_unit (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic                            action,
    input  wire logic [khc_pkg::CODE_BITS-1:0]   data_word,
    input  wire logic                            last_word,
    output logic                                 done,
    output logic [khc_pkg::CODE_BITS-1:0]        result_word,
    output logic                                 word_corrected,
    output logic                                 last_out,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire khc_pkg::table_t                 cfg_data
);

    khc_pkg::table_t   perm_table_reg;
    khc_pkg::idx_arr_t inv_table;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            perm_table_reg <= khc_pkg::TABLE_RESET;
        else if (cfg_valid && cfg_ready)
            perm_table_reg <= cfg_data;
    end

    khc_inv_table u_inv (
        .clk        (clk),
        .rst_n      (rst_n),
        .perm_table (perm_table_reg),
        .inv_table  (inv_table)
    );

    khc_pipe u_pipe (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (start && !busy),
        .action         (action),
        .data_word      (data_word),
        .last_word      (last_word),
        .perm_table     (perm_table_reg),
        .inv_table      (inv_table),
        .done           (done),
        .result_word    (result_word),
        .word_corrected (word_corrected),
        .last_out       (last_out)
    );

endmodule

`default_nettype wire

// ----- hdl/khc_checker.sv -----
// Port-level checks on the codec top level, attached by bind.
// Depends on keyed_hamming_15_11_codec_unit.
`default_nettype none

module khc_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        start,
    input wire logic        busy,
    input wire logic        action,
    input wire logic        last_word,
    input wire logic        done,
    input wire logic [14:0] result_word,
    input wire logic        word_corrected,
    input wire logic        last_out
);

    a_done_follows_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##4 done)
        else $error("accepted word produced no result");

    a_done_has_start: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 4))
        else $error("result without an accepted word");

    a_last_copied: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (last_out == $past(last_word, 4)))
        else $error("last_out does not match its word");

    a_encode_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !$past(action, 4)) |-> !word_corrected)
        else $error("encode result flagged as corrected");

    a_decode_width: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(action, 4)) |-> (result_word[14:11] == 4'd0))
        else $error("decode result has upper bits set");

endmodule

bind keyed_hamming_15_11_codec_unit khc_checker u_khc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .action         (action),
    .last_word      (last_word),
    .done           (done),
    .result_word    (result_word),
    .word_corrected (word_corrected),
    .last_out       (last_out)
);

`default_nettype wire

// ----- sim/keyed_hamming_15_11_codec_unit_tb.sv -----
// Self-checking testbench for keyed_hamming_15_11_codec_unit: encode and decode words
// through the keyed permutation and compare each result with a built-in predictor.
// Depends on khc_pkg and the codec RTL only.
module keyed_hamming_15_11_codec_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import khc_pkg::*;

    typedef struct packed {
        code_t word;
        logic  corrected;
        logic  last;
    } codec_result_t;

    logic   clk = 1'b0;
    logic   rst_n;
    logic   start;
    logic   busy;
    logic   action;
    code_t  data_word;
    logic   last_word;
    logic   done;
    code_t  result_word;
    logic   word_corrected;
    logic   last_out;
    logic   cfg_valid;
    logic   cfg_ready;
    table_t cfg_data;

    table_t        perm_shadow = TABLE_RESET;
    codec_result_t pending_words[$];
    int            mismatch_count = 0;
    int            max_gap = 7;

    keyed_hamming_15_11_codec_unit DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .action         (action),
        .data_word      (data_word),
        .last_word      (last_word),
        .done           (done),
        .result_word    (result_word),
        .word_corrected (word_corrected),
        .last_out       (last_out),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic code_t build_codeword(input logic [DATA_BITS-1:0] d);
        code_t code;
        int    k;
        logic  par;
        code = '0;
        k    = DATA_BITS - 1;
        for (int pos = 1; pos <= CODE_BITS; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                code[CODE_BITS-pos] = d[k];
                k--;
            end
        end
        for (int p = 0; p < PAR_BITS; p++)
        begin
            par = 1'b0;
            for (int pos = 1; pos <= CODE_BITS; pos++)
            begin
                if (pos[p])
                    par ^= code[CODE_BITS-pos];
            end
            code[CODE_BITS-(1 << p)] = par;
        end
        return code;
    endfunction

    function automatic synd_t check_bits(input code_t code);
        synd_t s;
        s = '0;
        for (int p = 0; p < PAR_BITS; p++)
        begin
            for (int pos = 1; pos <= CODE_BITS; pos++)
            begin
                if (pos[p])
                    s[p] ^= code[CODE_BITS-pos];
            end
        end
        return s;
    endfunction

    function automatic logic [DATA_BITS-1:0] gather_data(input code_t code);
        logic [DATA_BITS-1:0] d;
        int                   k;
        d = '0;
        k = DATA_BITS - 1;
        for (int pos = 1; pos <= CODE_BITS; pos++)
        begin
            if ((pos & (pos - 1)) != 0)
            begin
                d[k] = code[CODE_BITS-pos];
                k--;
            end
        end
        return d;
    endfunction

    function automatic code_t scramble_code(input code_t code, input table_t tbl);
        code_t out;
        idx_t  src;
        out = '0;
        for (int dst = 0; dst < CODE_BITS; dst++)
        begin
            src = tbl[IDX_BITS*dst +: IDX_BITS];
            if (src != idx_t'(CODE_BITS))
                out[CODE_BITS-1-dst] = code[CODE_BITS-1-src];
        end
        return out;
    endfunction

    function automatic code_t unscramble_code(input code_t rx, input table_t tbl);
        code_t out;
        int    src;
        out = '0;
        for (int j = 0; j < CODE_BITS; j++)
        begin
            src = 0;
            for (int i = 0; i < CODE_BITS; i++)
            begin
                if (tbl[IDX_BITS*i +: IDX_BITS] == idx_t'(j))
                    src = i;
            end
            out[CODE_BITS-1-j] = rx[CODE_BITS-1-src];
        end
        return out;
    endfunction

    function automatic codec_result_t predict_codec(input logic act, input code_t word,
                                                    input logic last);
        codec_result_t r;
        code_t         code;
        synd_t         s;
        r.last      = last;
        r.corrected = 1'b0;
        if (act == ACT_ENCODE)
            r.word = scramble_code(build_codeword(word[DATA_BITS-1:0]), perm_shadow);
        else
        begin
            code = unscramble_code(word, perm_shadow);
            s    = check_bits(code);
            if (s != '0)
            begin
                code[CODE_BITS-s] = ~code[CODE_BITS-s];
                r.corrected       = 1'b1;
            end
            r.word = {{(CODE_BITS-DATA_BITS){1'b0}}, gather_data(code)};
        end
        return r;
    endfunction

    function automatic code_t clean_codeword(input logic [DATA_BITS-1:0] d);
        return scramble_code(build_codeword(d), perm_shadow);
    endfunction

    function automatic table_t random_perm_table();
        int     slot[CODE_BITS];
        int     k;
        int     t;
        table_t tbl;
        for (int i = 0; i < CODE_BITS; i++)
            slot[i] = i;
        for (int i = CODE_BITS - 1; i > 0; i--)
        begin
            k       = $urandom_range(0, i);
            t       = slot[i];
            slot[i] = slot[k];
            slot[k] = t;
        end
        tbl = '0;
        for (int i = 0; i < CODE_BITS; i++)
            tbl[IDX_BITS*i +: IDX_BITS] = idx_t'(slot[i]);
        return tbl;
    endfunction

    function automatic table_t random_raw_table();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[TBL_BITS-1:0];
    endfunction

    task automatic send_word(input logic act, input code_t word, input logic last);
        int gap;
        gap = $urandom_range(0, max_gap);
        if (gap > 0)
        begin
            @(negedge clk) start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start     <= 1'b1;
        action    <= act;
        data_word <= word;
        last_word <= last;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        pending_words.push_back(predict_codec(act, word, last));
    endtask

    task automatic drain_results();
        @(negedge clk) start <= 1'b0;
        while (pending_words.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_table(input table_t value);
        drain_results();
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        perm_shadow = value;
        @(negedge clk) cfg_valid <= 1'b0;
    endtask

    task automatic test_reset_identity();
        code_t cw;
        cw = clean_codeword(11'h5A5);
        send_word(ACT_ENCODE, 15'h0000, 1'b0);
        send_word(ACT_ENCODE, 15'h07FF, 1'b1);
        send_word(ACT_ENCODE, 15'h7FFF, 1'b0);
        send_word(ACT_ENCODE, 15'h7800, 1'b1);
        send_word(ACT_ENCODE, 15'h02AA, 1'b0);
        send_word(ACT_DECODE, 15'h0000, 1'b0);
        send_word(ACT_DECODE, 15'h7FFF, 1'b1);
        send_word(ACT_DECODE, cw, 1'b0);
        send_word(ACT_DECODE, cw ^ 15'h0001, 1'b0);
        send_word(ACT_DECODE, cw ^ CODE_MSB, 1'b1);
        send_word(ACT_DECODE, cw ^ 15'h0003, 1'b0);
    endtask

    task automatic test_degenerate_tables();
        write_table({TBL_BITS{1'b1}});
        send_word(ACT_ENCODE, 15'h07FF, 1'b0);
        send_word(ACT_DECODE, 15'h7FFF, 1'b1);
        send_word(ACT_DECODE, 15'h4000, 1'b0);
        write_table('0);
        send_word(ACT_ENCODE, 15'h07FF, 1'b1);
        send_word(ACT_DECODE, 15'h1234, 1'b0);
        send_word(ACT_DECODE, 15'h0001, 1'b1);
        write_table(60'hF0F_1234_5F67_89FA);
        send_word(ACT_ENCODE, 15'h0555, 1'b0);
        send_word(ACT_DECODE, 15'h2AAA, 1'b1);
        send_word(ACT_DECODE, 15'h5555, 1'b0);
    endtask

    task automatic test_random_traffic();
        table_t tbl;
        code_t  cw;
        int     kind;
        int     flips;
        for (int ph = 0; ph < 10; ph++)
        begin
            case (ph)
                0: tbl = TABLE_RESET;
                1: tbl = random_perm_table();
                2: tbl = random_raw_table();
                3: tbl = {TBL_BITS{1'b1}};
                4: tbl = '0;
                5: tbl = random_raw_table();
                default: tbl = random_perm_table();
            endcase
            write_table(tbl);
            for (int n = 0; n < 50; n++)
            begin
                if (n % 25 == 0)
                    max_gap = ($urandom_range(0, 2) == 0) ? 0 : 7;
                if ((ph == 1 && n == 25) || $urandom_range(0, 99) == 0)
                    drain_results();
                kind = $urandom_range(0, 9);
                if (kind < 4)
                    send_word(ACT_ENCODE, code_t'($urandom), 1'($urandom));
                else if (kind < 9)
                begin
                    cw    = clean_codeword(11'($urandom));
                    flips = $urandom_range(0, 3);
                    if (flips == 3)
                        flips = 2;
                    else if (flips == 2)
                        flips = 1;
                    repeat (flips)
                        cw[$urandom_range(0, CODE_BITS - 1)] ^= 1'b1;
                    send_word(ACT_DECODE, cw, 1'($urandom));
                end
                else
                    send_word(ACT_DECODE, code_t'($urandom), 1'($urandom));
            end
        end
        max_gap = 7;
    endtask

    always @(posedge clk)
    begin : result_check
        codec_result_t want;
        if (rst_n && done)
        begin
            if (pending_words.size() == 0)
            begin
                $error("unexpected result word %h", result_word);
                mismatch_count++;
            end
            else
            begin
                want = pending_words.pop_front();
                if (result_word !== want.word)
                begin
                    $error("result_word: expected %h, actual %h", want.word, result_word);
                    mismatch_count++;
                end
                if (word_corrected !== want.corrected)
                begin
                    $error("word_corrected: expected %b, actual %b",
                           want.corrected, word_corrected);
                    mismatch_count++;
                end
                if (last_out !== want.last)
                begin
                    $error("last_out: expected %b, actual %b", want.last, last_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n     = 1'b0;
        start     = 1'b0;
        action    = ACT_ENCODE;
        data_word = '0;
        last_word = 1'b0;
        cfg_valid = 1'b0;
        cfg_data  = '0;
        repeat (4) @(posedge clk);
        @(negedge clk) rst_n <= 1'b1;
        test_reset_identity();
        test_degenerate_tables();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0 && pending_words.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

// ----- keyed_hamming_15_11_codec_unit.f -----
hdl/khc_pkg.sv
hdl/khc_inv_table.sv
hdl/khc_pipe.sv
hdl/keyed_hamming_15_11_codec_unit.sv
hdl/khc_checker.sv
sim/keyed_hamming_15_11_codec_unit_tb.sv
